### rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, character codes and lookup functions for the Intel HEX
// data record encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // Default record length in data bytes
  localparam int RECORD_BYTES_DEF = 16;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int FILL_W = 5;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_SET_ADDR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_COLON   = 7'h3A;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;

  // End-of-file record ":00000001FF" plus newline
  localparam int EOF_LEN = 12;

  // Job kinds passed from front to back
  typedef enum logic [1:0] {
    JOB_SET_ADDR = 2'd0,
    JOB_APPEND   = 2'd1,
    JOB_END      = 2'd2
  } job_kind_t;

  // One classified command
  typedef struct packed {
    job_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
  } job_t;

  // Map a nibble to its uppercase hex character
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

  // Character of the end-of-file record at a position
  function automatic logic [CHAR_W-1:0] eof_char(input logic [3:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      4'd0:          c = CHAR_COLON;
      4'd8:          c = hex_char(4'h1);
      4'd9, 4'd10:   c = hex_char(4'hF);
      4'd11:         c = CHAR_NEWLINE;
      default:       c = hex_char(4'h0);
    endcase
    return c;
  endfunction

endpackage

### rtl/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front
// Accepts commands, classifies them into jobs and holds them in a two-entry
// queue for the back end. Unused command codes are taken and dropped.
// ----------------------------------------------------------------------------
module ihex_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ihex_pkg::CMD_W-1:0]  command,
  input  logic [ihex_pkg::ADDR_W-1:0] new_address,
  input  logic [ihex_pkg::BYTE_W-1:0] data_byte,
  output logic                        job_valid,
  output ihex_pkg::job_t              job,
  input  logic                        job_take
);
  import ihex_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       enq;
  logic       deq;
  job_t       job_in;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign job_valid = (count != 2'd0);
  assign deq       = job_take && job_valid;
  assign job       = slots[rd_ptr];

  // Classify the command into a job; drop the unused code
  always_comb begin
    job_in.addr = new_address;
    job_in.data = data_byte;
    enq         = accept;
    unique case (command)
      CMD_SET_ADDR: job_in.kind = JOB_SET_ADDR;
      CMD_APPEND:   job_in.kind = JOB_APPEND;
      CMD_END:      job_in.kind = JOB_END;
      CMD_UNUSED: begin
        job_in.kind = JOB_SET_ADDR;
        enq         = 1'b0;
      end
      default: begin
        job_in.kind = JOB_SET_ADDR;
        enq         = 1'b0;
      end
    endcase
  end

  // Write the queue slot
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= job_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      if (enq && !deq) begin
        count <= count + 2'd1;
      end else if (deq && !enq) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back
// Carries out jobs: buffers data bytes, tracks the record address and writes
// records into an output register, one character per cycle while it is free.
// ----------------------------------------------------------------------------
module ihex_back #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  ihex_pkg::job_t              job,
  output logic                        job_take,
  output logic                        empty,
  input  logic                        pop,
  output logic [ihex_pkg::CHAR_W-1:0] char_code,
  output logic                        last_char
);
  import ihex_pkg::*;

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(RECORD_BYTES);
  localparam logic [3:0] HEAD_LAST = 4'd8;
  localparam logic [3:0] EOF_LAST  = 4'(EOF_LEN - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_HEAD = 6'b000010,
    ST_DATA = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_NL   = 6'b010000,
    ST_EOF  = 6'b100000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [BYTE_W-1:0]   byte_buf [RECORD_BYTES];
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   ptr;
  logic [3:0]          idx;
  logic                nib;
  logic [BYTE_W-1:0]   sum;
  logic [ADDR_W-1:0]   address;
  logic [ADDR_W-1:0]   pend_addr;
  logic                pend_set;
  logic                pend_end;
  logic                out_valid;
  logic                out_free;
  logic                emit;
  logic [CHAR_W-1:0]   emit_char;
  logic                emit_last;
  logic [BYTE_W-1:0]   count8;
  logic [BYTE_W-1:0]   cur_byte;
  logic [BYTE_W-1:0]   csum;
  logic [BYTE_W-1:0]   sel_byte;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign count8   = {{(BYTE_W-FILL_W){1'b0}}, fill};
  assign cur_byte = byte_buf[ptr[IDX_W-1:0]];
  assign csum     = 8'h00 - sum;
  assign job_take = (state == ST_IDLE) && job_valid;

  // Pick the character for the current step
  always_comb begin
    emit       = 1'b0;
    emit_char  = CHAR_NEWLINE;
    emit_last  = 1'b0;
    sel_byte   = cur_byte;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        state_next = ST_IDLE;
      end
      ST_HEAD: begin
        emit = out_free;
        case (idx)
          4'd0:    emit_char = CHAR_COLON;
          4'd1:    emit_char = hex_char(count8[7:4]);
          4'd2:    emit_char = hex_char(count8[3:0]);
          4'd3:    emit_char = hex_char(address[15:12]);
          4'd4:    emit_char = hex_char(address[11:8]);
          4'd5:    emit_char = hex_char(address[7:4]);
          4'd6:    emit_char = hex_char(address[3:0]);
          default: emit_char = hex_char(4'h0);
        endcase
        if (idx == HEAD_LAST) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        emit      = out_free;
        emit_char = hex_char(nib ? sel_byte[3:0] : sel_byte[7:4]);
        if (nib && (ptr + 5'd1 == fill)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        emit      = out_free;
        emit_char = hex_char(nib ? csum[3:0] : csum[7:4]);
        if (nib) begin
          state_next = ST_NL;
        end
      end
      ST_NL: begin
        emit       = out_free;
        emit_char  = CHAR_NEWLINE;
        emit_last  = !pend_end;
        state_next = pend_end ? ST_EOF : ST_IDLE;
      end
      ST_EOF: begin
        emit      = out_free;
        emit_char = eof_char(idx);
        emit_last = (idx == EOF_LAST);
        if (idx == EOF_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store appended bytes
  always_ff @(posedge clk) begin
    if (job_take && (job.kind == JOB_APPEND)) begin
      byte_buf[fill[IDX_W-1:0]] <= job.data;
    end
  end

  // Capture the job address on each take for a pending set-address job
  always_ff @(posedge clk) begin
    if (job_take) begin
      pend_addr <= job.addr;
    end
  end

  // Sequence jobs and record text
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      ptr      <= '0;
      idx      <= '0;
      nib      <= 1'b0;
      sum      <= '0;
      address  <= '0;
      pend_set <= 1'b0;
      pend_end <= 1'b0;
    end else if (state == ST_IDLE) begin
      idx <= '0;
      nib <= 1'b0;
      ptr <= '0;
      if (job_take) begin
        pend_set <= (job.kind == JOB_SET_ADDR);
        pend_end <= (job.kind == JOB_END);
        unique case (job.kind)
          JOB_SET_ADDR: begin
            if (fill != '0) begin
              state <= ST_HEAD;
            end else begin
              address <= job.addr;
            end
          end
          JOB_APPEND: begin
            fill <= fill + 5'd1;
            if (fill + 5'd1 == FULL_COUNT) begin
              state <= ST_HEAD;
            end
          end
          JOB_END: begin
            state <= (fill != '0) ? ST_HEAD : ST_EOF;
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end else if (emit) begin
      state <= state_next;
      unique case (state)
        ST_HEAD: begin
          if (idx == 4'd0) begin
            sum <= count8 + address[15:8] + address[7:0];
          end
          idx <= (idx == HEAD_LAST) ? 4'd0 : idx + 4'd1;
        end
        ST_DATA: begin
          nib <= !nib;
          if (nib) begin
            sum <= sum + cur_byte;
            ptr <= ptr + 5'd1;
          end
        end
        ST_SUM: begin
          nib <= !nib;
        end
        ST_NL: begin
          address <= pend_set ? pend_addr : address + {{(ADDR_W-FILL_W){1'b0}}, fill};
          fill    <= '0;
          idx     <= '0;
        end
        ST_EOF: begin
          idx <= idx + 4'd1;
        end
        default: begin
          idx <= idx;
        end
      endcase
    end
  end

  // Load the output register; drop it when popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_code <= emit_char;
      last_char <= emit_last;
    end
  end

endmodule

### rtl/intel_hex_record_encoder.sv
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Turns set-address, append-byte and end-of-file commands into Intel HEX
// type-00 data and type-01 end-of-file record text, one ASCII character per result word.
// ----------------------------------------------------------------------------
// Input queue: drive command, new_address and data_byte with push; a word is
// taken on a clock edge with push high and full low. Up to two commands wait
// in the front queue while a record is being written.
// Output queue: while empty is low, char_code and last_char show the oldest
// character; pop takes it. last_char marks the final character of a command.
// Throughput: one character per cycle while pop keeps up; the job sequencer
// writes no character while it takes a command. A full record of N bytes is
// 2*N+12 characters (44 at 16 bytes); an end of file adds 12 characters. The
// single character output register sets the pace.
// Latency: a command goes through the queue, sequencer and output register.
// Reset: clears the queue, fill count and record address to zero.
// Stall: a held character with pop low stalls the sequencer, and once the
// front queue fills, full rises and holds the sender.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [ihex_pkg::CMD_W-1:0]  command,
  input  logic [ihex_pkg::ADDR_W-1:0] new_address,
  input  logic [ihex_pkg::BYTE_W-1:0] data_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [ihex_pkg::CHAR_W-1:0] char_code,
  output logic                        last_char
);
  import ihex_pkg::*;

  logic job_valid;
  logic job_take;
  job_t job;

  // Classify commands and queue them
  ihex_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .new_address (new_address),
    .data_byte   (data_byte),
    .job_valid   (job_valid),
    .job         (job),
    .job_take    (job_take)
  );

  // Buffer bytes and write record text
  ihex_back #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule
